// ----- rtl/sorted_list_table_top_assert.svh -----
// ----------------------------------------------------------------------------
// sorted_list_table_top_assert.svh
// Assertion macros for the sorted list table. Expect clk and arst_n in scope.
// ----------------------------------------------------------------------------
`ifndef SORTED_LIST_TABLE_TOP_ASSERT_SVH
`define SORTED_LIST_TABLE_TOP_ASSERT_SVH

// same-cycle implication
`define SLT_ASSERT_NOW(name, pre, post) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("sorted list table: assertion failed");

// next-cycle implication
`define SLT_ASSERT_NEXT(name, pre, post) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("sorted list table: assertion failed");

`endif

// ----- rtl/slt_pkg.sv -----
// ----------------------------------------------------------------------------
// slt_pkg
// Types and constants shared by the sorted list table modules.
// ----------------------------------------------------------------------------
package slt_pkg;

	localparam int CAPACITY_DEF = 16;
	localparam int VALUE_W      = 32;
	localparam int COUNT_W      = 5;

	typedef enum logic {
		REQ_INSERT = 1'b0,
		REQ_DELETE = 1'b1
	} req_type_t;

	typedef enum logic [2:0] {
		ST_INSERTED = 3'd0,
		ST_DELETED  = 3'd1,
		ST_NOTFOUND = 3'd2,
		ST_FULL     = 3'd3,
		ST_EMPTY    = 3'd4
	} status_t;

	// broadcast to every cell
	typedef struct packed {
		logic                       ins;
		logic                       del;
		logic signed [VALUE_W-1:0]  value;
	} cell_ctrl_t;

endpackage

// ----- rtl/slt_req_if.sv -----
// ----------------------------------------------------------------------------
// slt_req_if
// Request channel: insert or delete one value.
// ----------------------------------------------------------------------------
interface slt_req_if;
	logic                               valid;
	logic                               ready;
	slt_pkg::req_type_t                 req_type;
	logic signed [slt_pkg::VALUE_W-1:0] value;

	modport source (output valid, output req_type, output value, input ready);
	modport sink   (input valid, input req_type, input value, output ready);
endinterface

// ----- rtl/slt_res_if.sv -----
// ----------------------------------------------------------------------------
// slt_res_if
// Result channel: status and entry count of one request.
// ----------------------------------------------------------------------------
interface slt_res_if;
	logic                          valid;
	logic                          ready;
	slt_pkg::status_t              status;
	logic [slt_pkg::COUNT_W-1:0]   entry_count;

	modport source (output valid, output status, output entry_count, input ready);
	modport sink   (input valid, input status, input entry_count, output ready);
endinterface

// ----- rtl/sorted_list_table_top.sv -----
// Sorted list table: ascending signed entries held in a row of compare cells.
// The result is valid in the cycle after its request is accepted. Throughput:
// one request per cycle unless an unread result stalls; all cells compare and
// shift in parallel, the critical path being a 32-bit compare plus the match OR
// over all cells. Reset: count clears to zero at once; entries are not cleared.
// ----------------------------------------------------------------------------
// sorted_list_table_top
// Insert/delete front end, entry counter and result register around the cells.
// ----------------------------------------------------------------------------
module sorted_list_table_top #(
	parameter int CAPACITY = slt_pkg::CAPACITY_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	slt_req_if.sink    req,
	slt_res_if.source  res
);
	import slt_pkg::*;

	`include "sorted_list_table_top_assert.svh"

	localparam int CW = $clog2(CAPACITY + 1);

	logic                      req_fire;
	logic                      full;
	logic                      empty;
	logic                      found;
	logic [CW-1:0]             count_q;
	logic [CW-1:0]             count_next;
	status_t                   status_next;
	cell_ctrl_t                ctrl;
	logic                      res_valid_q;
	status_t                   status_q;
	logic [COUNT_W-1:0]        entry_count_q;

	logic                      lt_w    [CAPACITY];
	logic                      eq_w    [CAPACITY];
	logic signed [VALUE_W-1:0] entry_w [CAPACITY];
	logic [CAPACITY-1:0]       eq_vec;

	assign req.ready = !res_valid_q || res.ready;
	assign req_fire  = req.valid && req.ready;

	assign full  = (count_q == CW'(CAPACITY));
	assign empty = (count_q == '0);
	assign found = |eq_vec;

	always_comb begin
		ctrl.value = req.value;
		ctrl.ins   = req_fire && (req.req_type == REQ_INSERT) && !full;
		ctrl.del   = req_fire && (req.req_type == REQ_DELETE) && found;
	end

	always_comb begin
		count_next = count_q;
		if (req.req_type == REQ_INSERT) begin
			status_next = full ? ST_FULL : ST_INSERTED;
			if (!full) count_next = count_q + 1'b1;
		end else if (empty) begin
			status_next = ST_EMPTY;
		end else if (found) begin
			status_next = ST_DELETED;
			count_next  = count_q - 1'b1;
		end else begin
			status_next = ST_NOTFOUND;
		end
	end

	genvar i;
	generate
		for (i = 0; i < CAPACITY; i++) begin : g_cell
			logic                      occ;
			logic                      left_lt;
			logic signed [VALUE_W-1:0] left_entry;
			logic signed [VALUE_W-1:0] right_entry;

			assign occ       = (CW'(i) < count_q);
			assign eq_vec[i] = eq_w[i];

			if (i == 0) begin : g_head
				assign left_lt    = 1'b1;
				assign left_entry = req.value;
			end else begin : g_body
				assign left_lt    = lt_w[i-1];
				assign left_entry = entry_w[i-1];
			end

			// past the end the slot becomes unoccupied; its contents do not matter
			if (i == CAPACITY - 1) begin : g_tail
				assign right_entry = entry_w[i];
			end else begin : g_mid
				assign right_entry = entry_w[i+1];
			end

			slt_cell u_cell (
				.clk         (clk),
				.ctrl        (ctrl),
				.occupied    (occ),
				.left_lt     (left_lt),
				.left_entry  (left_entry),
				.right_entry (right_entry),
				.lt          (lt_w[i]),
				.eq          (eq_w[i]),
				.entry       (entry_w[i])
			);
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (req_fire) begin
				count_q     <= count_next;
				res_valid_q <= 1'b1;
			end else if (res.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_fire) begin
			status_q      <= status_next;
			entry_count_q <= COUNT_W'(count_next);
		end
	end

	assign res.valid       = res_valid_q;
	assign res.status      = status_q;
	assign res.entry_count = entry_count_q;

	`SLT_ASSERT_NOW(a_count_bound, 1'b1, count_q <= CW'(CAPACITY))
	`SLT_ASSERT_NEXT(a_insert_grows, ctrl.ins, count_q == $past(count_q) + 1'b1)
	`SLT_ASSERT_NEXT(a_delete_shrinks, ctrl.del, count_q == $past(count_q) - 1'b1)
	`SLT_ASSERT_NOW(a_found_nonempty, found, !empty)

endmodule

// ----- rtl/slt_cell.sv -----
// ----------------------------------------------------------------------------
// slt_cell
// One table slot: compares its entry against the request value and either
// keeps it, loads the new value, or takes a neighbor's entry.
// ----------------------------------------------------------------------------
module slt_cell (
	input  logic                               clk,
	input  slt_pkg::cell_ctrl_t                ctrl,
	input  logic                               occupied,
	input  logic                               left_lt,
	input  logic signed [slt_pkg::VALUE_W-1:0] left_entry,
	input  logic signed [slt_pkg::VALUE_W-1:0] right_entry,
	output logic                               lt,
	output logic                               eq,
	output logic signed [slt_pkg::VALUE_W-1:0] entry
);
	import slt_pkg::*;

	logic signed [VALUE_W-1:0] entry_q;

	assign lt    = occupied && (entry_q < ctrl.value);
	assign eq    = occupied && (entry_q == ctrl.value);
	assign entry = entry_q;

	// insert: first non-smaller slot takes the value, slots above shift right
	// delete: every non-smaller slot takes its right neighbor
	always_ff @(posedge clk) begin
		if (ctrl.ins && !lt) begin
			entry_q <= left_lt ? ctrl.value : left_entry;
		end else if (ctrl.del && !lt) begin
			entry_q <= right_entry;
		end
	end

endmodule

// ----- test/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Sorted list table check: directed corner requests, fill/drain to both ends,
// biased random insert/delete traffic and a long result back-pressure stall.
// A queue-based shadow table predicts status and entry count for every request.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import slt_pkg::*;

	localparam int TABLE_DEPTH = CAPACITY_DEF;
	localparam int CYCLE_LIMIT = 400000;
	localparam int SETTLE_CYCLES = 10;
	localparam int REPORT_LIMIT = 10;

	typedef logic signed [VALUE_W-1:0] entry_t;

	typedef struct packed {
		status_t             status;
		logic [COUNT_W-1:0]  entry_count;
	} outcome_t;

	localparam entry_t VAL_MIN = 32'sh8000_0000;
	localparam entry_t VAL_MAX = 32'sh7fff_ffff;

	logic clk = 1'b0;
	logic arst_n;

	slt_req_if req_ch ();
	slt_res_if res_ch ();

	sorted_list_table_top #(.CAPACITY(TABLE_DEPTH)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.res    (res_ch)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// shadow copy of the table and results still owed by the block
	entry_t   shadow_table[$];
	outcome_t pending_results[$];

	int src_idle_max = 7;
	int sink_idle_max = 7;
	int hold_off_cycles = 0;
	int cycle_count = 0;
	int mismatches = 0;
	int requests_sent = 0;
	int results_seen = 0;
	int peak_fill = 0;
	int status_tally[5];

	function automatic outcome_t apply_request(input req_type_t op, input entry_t v);
		outcome_t o;
		int pos;
		pos = 0;
		if (op == REQ_INSERT) begin
			if (shadow_table.size() >= TABLE_DEPTH) begin
				o.status = ST_FULL;
			end else begin
				// lands ahead of every equal entry
				foreach (shadow_table[i])
					if (shadow_table[i] < v)
						pos++;
				shadow_table.insert(pos, v);
				o.status = ST_INSERTED;
			end
		end else if (shadow_table.size() == 0) begin
			o.status = ST_EMPTY;
		end else begin
			pos = -1;
			foreach (shadow_table[i])
				if (pos < 0 && shadow_table[i] == v)
					pos = i;
			if (pos < 0) begin
				o.status = ST_NOTFOUND;
			end else begin
				shadow_table.delete(pos);
				o.status = ST_DELETED;
			end
		end
		o.entry_count = COUNT_W'(shadow_table.size());
		status_tally[int'(o.status)]++;
		if (shadow_table.size() > peak_fill)
			peak_fill = shadow_table.size();
		return o;
	endfunction

	function automatic entry_t stored_value();
		return shadow_table[$urandom_range(0, shadow_table.size() - 1)];
	endfunction

	// small values collide often, wide ones toggle every bit
	function automatic entry_t draw_value();
		int sel;
		sel = $urandom_range(0, 9);
		if (sel < 5)
			return entry_t'(int'($urandom_range(0, 16)) - 8);
		if (sel < 7 && shadow_table.size() > 0)
			return stored_value();
		if (sel < 8) begin
			case ($urandom_range(0, 3))
				0: return VAL_MIN;
				1: return VAL_MAX;
				2: return VAL_MIN + 1;
				default: return VAL_MAX - 1;
			endcase
		end
		return entry_t'($urandom);
	endfunction

	// returns at the edge the request was taken; valid stays up for a follow-on
	task automatic send_request(input req_type_t op, input entry_t v);
		int gap;
		gap = $urandom_range(0, src_idle_max);
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid    <= 1'b1;
		req_ch.req_type <= op;
		req_ch.value    <= v;
		do @(posedge clk); while (!req_ch.ready);
		pending_results.push_back(apply_request(op, v));
		requests_sent++;
	endtask

	initial begin : result_sink
		int wait_cycles;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_off_cycles > 0) begin
				wait_cycles = hold_off_cycles;
				hold_off_cycles = 0;
			end else begin
				wait_cycles = $urandom_range(0, sink_idle_max);
			end
			if (wait_cycles > 0) begin
				res_ch.ready <= 1'b0;
				repeat (wait_cycles) @(posedge clk);
			end
			res_ch.ready <= 1'b1;
			do @(posedge clk); while (!res_ch.valid);
		end
	end

	always @(posedge clk) begin : check_results
		outcome_t want;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			results_seen++;
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT)
					$display("cycle %0d: result with nothing pending: status %0d count %0d",
						cycle_count, res_ch.status, res_ch.entry_count);
			end else begin
				want = pending_results.pop_front();
				if (res_ch.status !== want.status
						|| res_ch.entry_count !== want.entry_count) begin
					mismatches++;
					if (mismatches <= REPORT_LIMIT)
						$display("cycle %0d: status exp %0d got %0d, count exp %0d got %0d",
							cycle_count, want.status, res_ch.status,
							want.entry_count, res_ch.entry_count);
				end
			end
		end
	end

	initial begin : watchdog
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("timeout after %0d cycles, %0d results pending",
			cycle_count, pending_results.size());
		$display("== FAIL ==");
		$finish;
	end

	task automatic test_corner_values();
		send_request(REQ_DELETE, 0);
		send_request(REQ_INSERT, VAL_MAX);
		send_request(REQ_INSERT, VAL_MIN);
		send_request(REQ_INSERT, 0);
		send_request(REQ_INSERT, -1);
		send_request(REQ_INSERT, 0);
		send_request(REQ_INSERT, VAL_MIN);
		send_request(REQ_DELETE, 5);
		send_request(REQ_DELETE, 0);
		send_request(REQ_DELETE, VAL_MIN);
		send_request(REQ_DELETE, VAL_MAX);
		send_request(REQ_DELETE, VAL_MAX);
		send_request(REQ_DELETE, -1);
		send_request(REQ_DELETE, VAL_MIN);
		send_request(REQ_DELETE, 0);
		send_request(REQ_DELETE, 0);
	endtask

	task automatic test_fill_and_drain();
		src_idle_max = 3;
		sink_idle_max = 3;
		while (shadow_table.size() < TABLE_DEPTH)
			send_request(REQ_INSERT, draw_value());
		send_request(REQ_INSERT, VAL_MAX);
		send_request(REQ_INSERT, VAL_MIN);
		send_request(REQ_DELETE, stored_value());
		send_request(REQ_INSERT, VAL_MIN);
		while (shadow_table.size() > 0)
			send_request(REQ_DELETE, stored_value());
		send_request(REQ_DELETE, VAL_MAX);
	endtask

	task automatic test_random_traffic();
		int insert_pct;
		req_type_t op;
		for (int round = 0; round < 6; round++) begin
			if (round == 4) begin
				src_idle_max = 0;
				sink_idle_max = 0;
			end else begin
				src_idle_max = 7;
				sink_idle_max = 7;
			end
			case (round % 3)
				0: insert_pct = 75;
				1: insert_pct = 30;
				default: insert_pct = 55;
			endcase
			for (int n = 0; n < 250; n++) begin
				op = ($urandom_range(0, 99) < insert_pct) ? REQ_INSERT : REQ_DELETE;
				if (op == REQ_DELETE && shadow_table.size() > 0 && $urandom_range(0, 9) < 6)
					send_request(op, stored_value());
				else
					send_request(op, draw_value());
			end
		end
	endtask

	task automatic test_result_backpressure();
		src_idle_max = 0;
		sink_idle_max = 2;
		hold_off_cycles = 300;
		for (int n = 0; n < 40; n++)
			send_request(($urandom_range(0, 1) != 0) ? REQ_DELETE : REQ_INSERT, draw_value());
	endtask

	initial begin : main
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.req_type = REQ_INSERT;
		req_ch.value = '0;
		res_ch.ready = 1'b0;
		foreach (status_tally[i])
			status_tally[i] = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_corner_values();
		test_fill_and_drain();
		test_random_traffic();
		test_result_backpressure();

		req_ch.valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("%0d requests, %0d results: %0d inserted, %0d deleted, %0d not found,",
			requests_sent, results_seen, status_tally[int'(ST_INSERTED)],
			status_tally[int'(ST_DELETED)], status_tally[int'(ST_NOTFOUND)]);
		$display("%0d refused full, %0d on empty table, peak fill %0d of %0d, %0d mismatches",
			status_tally[int'(ST_FULL)], status_tally[int'(ST_EMPTY)],
			peak_fill, TABLE_DEPTH, mismatches);
		if (mismatches == 0 && pending_results.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

// ----- sorted_list_table_top.f -----
+incdir+rtl
rtl/slt_pkg.sv
rtl/slt_req_if.sv
rtl/slt_res_if.sv
rtl/slt_cell.sv
rtl/sorted_list_table_top.sv
test/testbench.sv
